// ===== hw/rtl/wam_pkg.sv =====
// Shared types and constants for the windowed average latency monitor.
// Holds field widths, the snapshot word layout and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package wam_pkg;

  // Field widths of the input and result words.
  localparam int MIN_W  = 32;
  localparam int LAT_W  = 32;
  localparam int WIN_W  = 6;
  localparam int AVG_W  = 42;

  // Running totals and the scaled dividend.
  localparam int TOT_W  = 64;
  localparam int SAMP_W = 48;
  localparam int PROD_W = TOT_W + 10;
  localparam int STEP_W = $clog2(PROD_W + 1);

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Saturated average.
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  // One ring entry: both totals at a minute boundary.
  typedef struct packed {
    logic [TOT_W-1:0]  lat;
    logic [SAMP_W-1:0] cnt;
  } snap_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CATCH,
    ST_APPLY,
    ST_WRAP,
    ST_READ,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/wam_ifs.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on wam_pkg for the field widths.
`timescale 1ns / 1ps

interface wam_in_if;
  import wam_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [MIN_W-1:0] cur_minute;
  logic [LAT_W-1:0] lat_us;
  logic [WIN_W-1:0] window_minutes;

  modport source (output valid, kind, cur_minute, lat_us, window_minutes,
                  input ready);
  modport sink   (input valid, kind, cur_minute, lat_us, window_minutes,
                  output ready);
endinterface

interface wam_out_if;
  import wam_pkg::*;

  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average_ns;
  logic             window_empty;

  modport source (output valid, average_ns, window_empty, input ready);
  modport sink   (input valid, average_ns, window_empty, output ready);
endinterface

// ===== hw/rtl/windowed_average_latency_monitor.sv =====
// Windowed average latency monitor. After reset the block clears all SLOTS entries
// of the snapshot ring and takes no word meanwhile. It handles one word at a time:
// a sample first writes one snapshot per elapsed minute (min(elapsed minutes, SLOTS))
// and then adds into the totals; a query does the same catch-up, then adds SLOTS to a
// negative ring index where needed (at most once when SLOTS is 64), reads the snapshot,
// scales the latency difference and runs the 74-step restoring divider. A query whose
// window is empty skips the divider. A query holds in its last state while the
// previous result word still waits on out_ch. A zero-latency sample is dropped.
`timescale 1ns / 1ps

module windowed_average_latency_monitor #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  wam_in_if.sink           in_ch,
  wam_out_if.source        out_ch
);
  import wam_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int DIF_W = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 2;

  state_t state_r, state_nxt;

  // Control state.
  logic [TOT_W-1:0]  lat_tot_r;
  logic [SAMP_W-1:0] cnt_tot_r;
  logic [MIN_W-1:0]  last_minute_r;
  logic [IDX_W-1:0]  write_slot_r;
  logic [CNT_W-1:0]  catch_cnt_r;
  logic              out_valid_r;

  // Item and working registers.
  logic              kind_r;
  logic [LAT_W-1:0]  lat_r;
  logic [WIN_W-1:0]  win_r;
  logic [DIF_W-1:0]  diff_r;
  logic [TOT_W-1:0]  dl_r;
  logic [SAMP_W-1:0] dc_r;
  logic [PROD_W-1:0] prod_r;
  logic [AVG_W-1:0]  avg_r;
  logic              empty_r;
  logic [AVG_W-1:0]  out_avg_r;
  logic              out_empty_r;

  // Combinational helpers.
  logic              in_acc;
  logic              drop;
  logic [MIN_W-1:0]  elapsed;
  logic [CNT_W-1:0]  catch_n;
  logic [IDX_W-1:0]  slot_inc;
  logic              diff_neg;
  logic              out_free;

  // Ring and divider hookup.
  logic              wr_en;
  snap_t             wr_data;
  logic              rd_en;
  snap_t             rd_data;
  logic              div_start;
  logic              div_done;
  logic [AVG_W-1:0]  div_q;

  // Handshake and catch-up count.
  always_comb begin
    in_acc   = in_ch.valid && in_ch.ready;
    drop     = (in_ch.kind == KIND_SAMPLE) && (in_ch.lat_us == '0);
    elapsed  = in_ch.cur_minute - last_minute_r;
    if (in_ch.cur_minute <= last_minute_r) begin
      catch_n = '0;
    end else if (elapsed >= MIN_W'(SLOTS)) begin
      catch_n = CNT_W'(SLOTS);
    end else begin
      catch_n = elapsed[CNT_W-1:0];
    end
    slot_inc = (write_slot_r == IDX_W'(SLOTS - 1)) ? '0 : write_slot_r + 1'b1;
    diff_neg = diff_r[DIF_W-1];
    out_free = !out_valid_r || out_ch.ready;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (write_slot_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && !drop) begin
          state_nxt = ST_CATCH;
        end
      end
      ST_CATCH: begin
        if (catch_cnt_r == '0) begin
          state_nxt = (kind_r == KIND_QUERY) ? ST_WRAP : ST_APPLY;
        end
      end
      ST_APPLY: state_nxt = ST_IDLE;
      ST_WRAP: begin
        if (!diff_neg) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = (dc_r == '0) ? ST_DONE : ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    wr_en       = (state_r == ST_CLEAR) || ((state_r == ST_CATCH) && (catch_cnt_r != '0));
    wr_data     = (state_r == ST_CLEAR) ? '0 : snap_t'{lat: lat_tot_r, cnt: cnt_tot_r};
    rd_en       = (state_r == ST_WRAP) && !diff_neg;
    div_start   = (state_r == ST_START);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      lat_tot_r     <= '0;
      cnt_tot_r     <= '0;
      last_minute_r <= '0;
      write_slot_r  <= '0;
      catch_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        write_slot_r <= slot_inc;
      end
      if ((state_r == ST_IDLE) && in_acc && !drop) begin
        last_minute_r <= in_ch.cur_minute;
        catch_cnt_r   <= catch_n;
      end
      if ((state_r == ST_CATCH) && (catch_cnt_r != '0)) begin
        write_slot_r <= slot_inc;
        catch_cnt_r  <= catch_cnt_r - 1'b1;
      end
      if (state_r == ST_APPLY) begin
        lat_tot_r <= lat_tot_r + TOT_W'(lat_r);
        cnt_tot_r <= cnt_tot_r + 1'b1;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers: item capture, ring index, differences, scaling.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_acc) begin
      kind_r <= in_ch.kind;
      lat_r  <= in_ch.lat_us;
      win_r  <= in_ch.window_minutes;
    end
    if ((state_r == ST_CATCH) && (catch_cnt_r == '0)) begin
      diff_r <= DIF_W'(write_slot_r) - DIF_W'(win_r);
    end
    if ((state_r == ST_WRAP) && diff_neg) begin
      diff_r <= diff_r + DIF_W'(SLOTS);
    end
    if (state_r == ST_READ) begin
      dl_r <= lat_tot_r - rd_data.lat;
      dc_r <= cnt_tot_r - rd_data.cnt;
    end
    // Times 1000 as 1024 - 16 - 8.
    if (state_r == ST_MUL) begin
      prod_r  <= (PROD_W'(dl_r) << 10) - (PROD_W'(dl_r) << 4) - (PROD_W'(dl_r) << 3);
      empty_r <= (dc_r == '0);
      avg_r   <= '0;
    end
    if ((state_r == ST_DIV) && div_done) begin
      avg_r <= div_q;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_avg_r   <= avg_r;
      out_empty_r <= empty_r;
    end
  end

  wam_ring #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_slot_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (diff_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  wam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (dc_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Result word.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.average_ns   = out_avg_r;
  assign out_ch.window_empty = out_empty_r;

endmodule

// ===== hw/rtl/wam_ring.sv =====
// Snapshot ring: one write port and one registered read port.
// Depends on wam_pkg for the snapshot word layout.
`timescale 1ns / 1ps

module wam_ring #(
  parameter int SLOTS = 64,
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  wam_pkg::snap_t     wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output wam_pkg::snap_t     rd_data
);
  import wam_pkg::*;

  snap_t mem [SLOTS];
  snap_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/wam_div.sv =====
// Restoring divider, one quotient bit per cycle, with a saturated quotient.
// Depends on wam_pkg for the dividend, divisor and quotient widths.
`timescale 1ns / 1ps

module wam_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wam_pkg::PROD_W-1:0]  dividend,
  input  logic [wam_pkg::SAMP_W-1:0]  divisor,
  output logic                        done,
  output logic [wam_pkg::AVG_W-1:0]   quotient
);
  import wam_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [PROD_W-1:0] num_r;
  logic [SAMP_W-1:0] den_r;
  logic [SAMP_W-1:0] rem_r;
  logic [AVG_W-1:0]  quo_r;
  logic              ovf_r;

  logic [SAMP_W:0]   rem_sh;
  logic [SAMP_W:0]   rem_sub;
  logic              ge;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    rem_sh  = {rem_r, num_r[PROD_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  // Step counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(PROD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift; bits pushed out of the top mark overflow.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[PROD_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[SAMP_W-1:0] : rem_sh[SAMP_W-1:0];
      quo_r <= {quo_r[AVG_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[AVG_W-1];
    end
  end

  assign done     = done_r;
  assign quotient = ovf_r ? AVG_MAX : quo_r;

endmodule
